### src/tle_pkg.sv
// Shared types and constants for the terminal line editor.
// Used by tle_ctrl, tle_datapath and terminal_line_editor_unit; no dependencies.
`default_nettype none

package tle_pkg;

	localparam int LINE_CAP_DEF   = 64;
	localparam int HIST_DEPTH_DEF = 5;

	localparam int BYTE_W = 8;
	localparam int KIND_W = 2;
	localparam int CHAR_W = 7;
	localparam int POS_W  = 7;

	localparam logic [BYTE_W-1:0] KEY_ESC   = 8'h1b;
	localparam logic [BYTE_W-1:0] KEY_DEL   = 8'h7f;
	localparam logic [BYTE_W-1:0] KEY_BS    = 8'h08;
	localparam logic [BYTE_W-1:0] KEY_CTRLC = 8'h03;
	localparam logic [BYTE_W-1:0] KEY_CR    = 8'h0d;
	localparam logic [BYTE_W-1:0] KEY_MAXCH = 8'h7f;
	localparam logic [BYTE_W-1:0] KEY_SPACE = 8'h20;
	localparam logic [BYTE_W-1:0] KEY_LBRK  = 8'h5b;
	localparam logic [BYTE_W-1:0] KEY_UP    = 8'h41;
	localparam logic [BYTE_W-1:0] KEY_DOWN  = 8'h42;
	localparam logic [BYTE_W-1:0] KEY_RIGHT = 8'h43;
	localparam logic [BYTE_W-1:0] KEY_LEFT  = 8'h44;
	localparam logic [BYTE_W-1:0] KEY_THREE = 8'h33;

	typedef enum logic [KIND_W-1:0] {
		KIND_STATUS = 2'd0,
		KIND_CHAR   = 2'd1,
		KIND_EMPTY  = 2'd2,
		KIND_CANCEL = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		ESC_NORMAL  = 2'd0,
		ESC_SEEN    = 2'd1,
		ESC_BRACKET = 2'd2,
		ESC_TILDE   = 2'd3
	} esc_t;

	typedef enum logic [2:0] {
		MODE_NONE,
		MODE_INS,
		MODE_DEL,
		MODE_LOAD,
		MODE_COMMIT
	} mode_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECODE,
		ST_LOOP_RD,
		ST_LOOP_WR,
		ST_EMIT
	} ctl_state_t;

	typedef struct packed {
		logic accept;
		logic decode;
		logic rd;
		logic wr;
		logic finish;
		logic emit;
	} dp_cmd_t;

	typedef struct packed {
		logic dec_loop;
		logic more;
		logic commit;
		logic out_free;
	} dp_status_t;

endpackage

`default_nettype wire

### src/terminal_line_editor_unit.sv
// Terminal line editor with history: top level joining controller and datapath.
// Depends on tle_pkg, tle_ctrl and tle_datapath.
//
// Input channel: in_valid, in_stall, rx_byte carry one received terminal byte per
// transaction. Output channel: out_valid, out_stall and the result fields carry
// one result per transaction; last_of_run marks the final result of a byte.
// A byte is taken in the idle state and decoded in the next cycle; for simple
// edits its status result is then loaded in the emit state once the output
// register is free. Insert and delete shift the line one character at a time
// through the line memory, alternating a read and a write state; a history
// recall copies the entry the same way. Carriage return delivers the line one
// character at a time while copying it into the history memory, which is a
// ring addressed by a head pointer so no entry is ever moved. Items are handled
// one at a time; the next byte is taken as soon as the previous one's last
// result sits in the output register. A stalled receiver holds the output
// register and the editor waits on it. Reset clears the line, the cursor, the
// escape state and marks every history entry empty; no clearing pass is needed.
`default_nettype none

module terminal_line_editor_unit #(
	parameter int LINE_CAP      = tle_pkg::LINE_CAP_DEF,
	parameter int HISTORY_DEPTH = tle_pkg::HIST_DEPTH_DEF
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              in_valid,
	output logic                             in_stall,
	input  wire [tle_pkg::BYTE_W-1:0]        rx_byte,
	output logic                             out_valid,
	input  wire                              out_stall,
	output logic [tle_pkg::KIND_W-1:0]       result_kind,
	output logic [tle_pkg::CHAR_W-1:0]       line_char,
	output logic [tle_pkg::POS_W-1:0]        cursor_pos,
	output logic [tle_pkg::POS_W-1:0]        line_len_out,
	output logic                             last_of_run
);

	tle_pkg::dp_cmd_t    cmd;
	tle_pkg::dp_status_t status;

	tle_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.status   (status),
		.cmd      (cmd)
	);

	tle_datapath #(
		.LINE_CAP      (LINE_CAP),
		.HISTORY_DEPTH (HISTORY_DEPTH)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.rx_byte      (rx_byte),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.result_kind  (result_kind),
		.line_char    (line_char),
		.cursor_pos   (cursor_pos),
		.line_len_out (line_len_out),
		.last_of_run  (last_of_run)
	);

endmodule

`default_nettype wire

### src/tle_ctrl.sv
// Controller state machine of the terminal line editor.
// Depends on tle_pkg; drives the datapath through dp_cmd_t and reads dp_status_t.
`default_nettype none

module tle_ctrl (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  in_valid,
	output logic                 in_stall,
	input  tle_pkg::dp_status_t  status,
	output tle_pkg::dp_cmd_t     cmd
);

	tle_pkg::ctl_state_t state_q, state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tle_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			tle_pkg::ST_IDLE: begin
				if (in_valid) state_nxt = tle_pkg::ST_DECODE;
			end
			tle_pkg::ST_DECODE: begin
				state_nxt = status.dec_loop ? tle_pkg::ST_LOOP_RD : tle_pkg::ST_EMIT;
			end
			tle_pkg::ST_LOOP_RD: begin
				if (status.more) begin
					state_nxt = tle_pkg::ST_LOOP_WR;
				end else begin
					// A committed line has already delivered all its results.
					state_nxt = status.commit ? tle_pkg::ST_IDLE : tle_pkg::ST_EMIT;
				end
			end
			tle_pkg::ST_LOOP_WR: begin
				if (!status.commit || status.out_free) state_nxt = tle_pkg::ST_LOOP_RD;
			end
			tle_pkg::ST_EMIT: begin
				if (status.out_free) state_nxt = tle_pkg::ST_IDLE;
			end
			default: state_nxt = tle_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_stall = 1'b1;
		unique case (state_q)
			tle_pkg::ST_IDLE: begin
				in_stall   = 1'b0;
				cmd.accept = in_valid;
			end
			tle_pkg::ST_DECODE: cmd.decode = 1'b1;
			tle_pkg::ST_LOOP_RD: begin
				cmd.rd     = status.more;
				cmd.finish = !status.more;
			end
			tle_pkg::ST_LOOP_WR: cmd.wr = !status.commit || status.out_free;
			tle_pkg::ST_EMIT: cmd.emit = status.out_free;
			default: cmd = '0;
		endcase
	end

endmodule

`default_nettype wire

### src/tle_datapath.sv
// Datapath of the terminal line editor: line and history memories, cursor,
// escape decoding and the result register. Depends on tle_pkg.
`default_nettype none

module tle_datapath #(
	parameter int LINE_CAP      = tle_pkg::LINE_CAP_DEF,
	parameter int HISTORY_DEPTH = tle_pkg::HIST_DEPTH_DEF
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  tle_pkg::dp_cmd_t                 cmd,
	output tle_pkg::dp_status_t              status,
	input  wire [tle_pkg::BYTE_W-1:0]        rx_byte,
	output logic                             out_valid,
	input  wire                              out_stall,
	output logic [tle_pkg::KIND_W-1:0]       result_kind,
	output logic [tle_pkg::CHAR_W-1:0]       line_char,
	output logic [tle_pkg::POS_W-1:0]        cursor_pos,
	output logic [tle_pkg::POS_W-1:0]        line_len_out,
	output logic                             last_of_run
);

	localparam int PW     = $clog2(LINE_CAP);
	localparam int LW     = $clog2(LINE_CAP + 1);
	localparam int HW     = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
	localparam int HW1    = HW + 1;
	localparam int HDEPTH = HISTORY_DEPTH * (2 ** PW);
	localparam int HAW    = $clog2(HDEPTH);
	localparam int CW     = tle_pkg::CHAR_W;

	logic [CW-1:0] line_mem [LINE_CAP];
	logic [CW-1:0] hist_mem [HDEPTH];

	logic [tle_pkg::BYTE_W-1:0] byte_q;
	tle_pkg::esc_t  esc_q, nxt_esc;
	tle_pkg::mode_t mode_q, dec_mode;
	tle_pkg::kind_t kind_q, dec_kind;
	logic [LW-1:0]  len_q, cur_q, idx_q, n_q;
	logic [LW-1:0]  nxt_len, nxt_cur, dec_idx, dec_n;
	logic [HW-1:0]  hsel_q, head_q, slot_q, nxt_hsel, dec_slot;
	logic [HW-1:0]  hs_up, hs_dn, load_sel, load_phys, head_prev;
	logic [LW-1:0]  hlen_q [HISTORY_DEPTH];
	logic [CW-1:0]  line_rd_q, hist_rd_q;

	logic           out_free, load_char;
	logic           line_we;
	logic [PW-1:0]  line_waddr, line_raddr;
	logic [CW-1:0]  line_wdata;
	logic [HAW-1:0] hist_addr_rd, hist_addr_wr;

	// Logical history entry zero is the slot at head_q; older entries follow.
	function automatic logic [HW-1:0] phys_slot(input logic [HW-1:0] head,
			input logic [HW-1:0] sel);
		logic [HW1-1:0] sum;
		sum = {1'b0, head} + {1'b0, sel};
		if (sum >= HW1'(HISTORY_DEPTH)) sum = sum - HW1'(HISTORY_DEPTH);
		return sum[HW-1:0];
	endfunction

	always_comb begin
		if ({1'b0, hsel_q} + HW1'(1) < HW1'(HISTORY_DEPTH)) hs_up = hsel_q + HW'(1);
		else hs_up = HW'(HISTORY_DEPTH - 1);
		hs_dn     = (hsel_q != '0) ? hsel_q - HW'(1) : '0;
		load_sel  = (byte_q == tle_pkg::KEY_UP) ? hsel_q : hs_dn;
		load_phys = phys_slot(head_q, load_sel);
		head_prev = (head_q == '0) ? HW'(HISTORY_DEPTH - 1) : head_q - HW'(1);
	end

	always_comb begin
		dec_mode = tle_pkg::MODE_NONE;
		dec_kind = tle_pkg::KIND_STATUS;
		nxt_esc  = esc_q;
		nxt_len  = len_q;
		nxt_cur  = cur_q;
		nxt_hsel = hsel_q;
		dec_idx  = cur_q;
		dec_n    = len_q;
		dec_slot = slot_q;
		if (byte_q <= tle_pkg::KEY_MAXCH) begin
			unique case (esc_q)
				tle_pkg::ESC_NORMAL: begin
					if (byte_q == tle_pkg::KEY_CR) begin
						if (len_q == '0) begin
							dec_kind = tle_pkg::KIND_EMPTY;
						end else begin
							dec_mode = tle_pkg::MODE_COMMIT;
							dec_idx  = '0;
							dec_slot = head_prev;
						end
					end else if (byte_q == tle_pkg::KEY_CTRLC) begin
						dec_kind = tle_pkg::KIND_CANCEL;
						nxt_len  = '0;
						nxt_cur  = '0;
					end else if (byte_q == tle_pkg::KEY_ESC) begin
						nxt_esc = tle_pkg::ESC_SEEN;
					end else if (byte_q == tle_pkg::KEY_BS) begin
						if (cur_q != '0) begin
							nxt_cur  = cur_q - LW'(1);
							dec_idx  = cur_q - LW'(1);
							dec_mode = tle_pkg::MODE_DEL;
						end
					end else if (byte_q == tle_pkg::KEY_DEL) begin
						if (cur_q < len_q) dec_mode = tle_pkg::MODE_DEL;
					end else if (byte_q >= tle_pkg::KEY_SPACE) begin
						if (len_q < LW'(LINE_CAP)) begin
							dec_mode = tle_pkg::MODE_INS;
							dec_idx  = len_q;
						end
					end
				end
				tle_pkg::ESC_SEEN: begin
					nxt_esc = (byte_q == tle_pkg::KEY_LBRK) ? tle_pkg::ESC_BRACKET
						: tle_pkg::ESC_NORMAL;
				end
				tle_pkg::ESC_BRACKET: begin
					nxt_esc = tle_pkg::ESC_NORMAL;
					if (byte_q == tle_pkg::KEY_UP || byte_q == tle_pkg::KEY_DOWN) begin
						dec_mode = tle_pkg::MODE_LOAD;
						dec_idx  = '0;
						dec_slot = load_phys;
						dec_n    = hlen_q[load_phys];
						nxt_hsel = (byte_q == tle_pkg::KEY_UP) ? hs_up : hs_dn;
					end else if (byte_q == tle_pkg::KEY_RIGHT) begin
						if (cur_q < len_q) nxt_cur = cur_q + LW'(1);
					end else if (byte_q == tle_pkg::KEY_LEFT) begin
						if (cur_q != '0) nxt_cur = cur_q - LW'(1);
					end else if (byte_q == tle_pkg::KEY_THREE) begin
						nxt_esc = tle_pkg::ESC_TILDE;
						if (cur_q < len_q) dec_mode = tle_pkg::MODE_DEL;
					end
				end
				tle_pkg::ESC_TILDE: nxt_esc = tle_pkg::ESC_NORMAL;
				default: nxt_esc = tle_pkg::ESC_NORMAL;
			endcase
		end
	end

	assign out_free  = !out_valid || !out_stall;
	assign load_char = cmd.wr && (mode_q == tle_pkg::MODE_COMMIT);

	always_comb begin
		status.dec_loop = (dec_mode != tle_pkg::MODE_NONE);
		status.commit   = (mode_q == tle_pkg::MODE_COMMIT);
		status.out_free = out_free;
		case (mode_q)
			tle_pkg::MODE_INS:    status.more = (idx_q > cur_q);
			tle_pkg::MODE_DEL:    status.more = ({1'b0, idx_q} + (LW+1)'(1) < {1'b0, len_q});
			tle_pkg::MODE_LOAD,
			tle_pkg::MODE_COMMIT: status.more = (idx_q < n_q);
			default:              status.more = 1'b0;
		endcase
	end

	always_comb begin
		case (mode_q)
			tle_pkg::MODE_INS: line_raddr = PW'(idx_q - LW'(1));
			tle_pkg::MODE_DEL: line_raddr = PW'(idx_q + LW'(1));
			default:           line_raddr = idx_q[PW-1:0];
		endcase
		hist_addr_rd = HAW'({slot_q, idx_q[PW-1:0]});
		hist_addr_wr = hist_addr_rd;
		line_we      = 1'b0;
		line_waddr   = idx_q[PW-1:0];
		line_wdata   = line_rd_q;
		if (cmd.wr) begin
			line_we = (mode_q != tle_pkg::MODE_COMMIT);
			if (mode_q == tle_pkg::MODE_LOAD) line_wdata = hist_rd_q;
		end else if (cmd.finish && mode_q == tle_pkg::MODE_INS) begin
			// The shift has opened a gap at the cursor for the new character.
			line_we    = 1'b1;
			line_waddr = cur_q[PW-1:0];
			line_wdata = byte_q[CW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (line_we) line_mem[line_waddr] <= line_wdata;
		if (load_char) hist_mem[hist_addr_wr] <= line_rd_q;
		if (cmd.rd) begin
			line_rd_q <= line_mem[line_raddr];
			hist_rd_q <= hist_mem[hist_addr_rd];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) byte_q <= rx_byte;
		if (cmd.decode) begin
			kind_q <= dec_kind;
			idx_q  <= dec_idx;
			n_q    <= dec_n;
			slot_q <= dec_slot;
		end else if (cmd.wr) begin
			if (mode_q == tle_pkg::MODE_INS) idx_q <= idx_q - LW'(1);
			else idx_q <= idx_q + LW'(1);
		end
		if (cmd.emit || load_char) begin
			result_kind  <= cmd.emit ? kind_q : tle_pkg::KIND_CHAR;
			line_char    <= cmd.emit ? '0 : line_rd_q;
			cursor_pos   <= cmd.emit ? tle_pkg::POS_W'(cur_q) : '0;
			line_len_out <= cmd.emit ? tle_pkg::POS_W'(len_q) : tle_pkg::POS_W'(n_q);
			last_of_run  <= cmd.emit || (idx_q + LW'(1) == n_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			esc_q     <= tle_pkg::ESC_NORMAL;
			mode_q    <= tle_pkg::MODE_NONE;
			len_q     <= '0;
			cur_q     <= '0;
			hsel_q    <= '0;
			head_q    <= '0;
			out_valid <= 1'b0;
			for (int i = 0; i < HISTORY_DEPTH; i++) hlen_q[i] <= '0;
		end else begin
			if (cmd.emit || load_char) out_valid <= 1'b1;
			else if (!out_stall) out_valid <= 1'b0;
			if (cmd.decode) begin
				esc_q  <= nxt_esc;
				mode_q <= dec_mode;
				len_q  <= nxt_len;
				cur_q  <= nxt_cur;
				hsel_q <= nxt_hsel;
			end
			if (cmd.finish) begin
				mode_q <= tle_pkg::MODE_NONE;
				case (mode_q)
					tle_pkg::MODE_INS: begin
						len_q <= len_q + LW'(1);
						cur_q <= cur_q + LW'(1);
					end
					tle_pkg::MODE_DEL: len_q <= len_q - LW'(1);
					tle_pkg::MODE_LOAD: begin
						len_q <= n_q;
						cur_q <= n_q;
					end
					tle_pkg::MODE_COMMIT: begin
						head_q         <= slot_q;
						hlen_q[slot_q] <= n_q;
						hsel_q         <= '0;
						len_q          <= '0;
						cur_q          <= '0;
					end
					default: len_q <= len_q;
				endcase
			end
		end
	end

endmodule

`default_nettype wire
